// File: hw/rtl/hqc_pkg.sv
package hqc_pkg;

	localparam int TABLE_SLOTS = 4096;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CODE_W      = 256;
	localparam int VAL_W       = 63;
	localparam logic [63:0] HASH_OFFSET = 64'd1469598103;
	localparam logic [63:0] HASH_PRIME  = 64'd16777619;
	localparam logic [SLOT_W:0] PROBE_MAX = (SLOT_W + 1)'(TABLE_SLOTS);

	typedef enum logic [2:0] {
		ST_UPDATED = 3'd0,
		ST_STALE   = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_FULL    = 3'd3,
		ST_OVFL    = 3'd4,
		ST_BAD     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_HASH,
		FSM_READ,
		FSM_CHECK,
		FSM_CLEAR,
		FSM_DONE
	} fsm_t;

	// Hash request and result between control and the hash unit.
	typedef struct packed {
		logic start;
		logic [5:0] len;
	} hash_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} hash_sts_t;

endpackage

// File: hw/rtl/hqc_ram.sv
module hqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/hqc_hash.sv
module hqc_hash import hqc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  hash_req_t         req,
	input  logic [CODE_W-1:0] code,
	output hash_sts_t         sts,
	output logic [63:0]       hash
);

	logic [63:0] h_q;
	logic [5:0]  idx_q;
	logic [5:0]  len_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  byte_c;
	logic [63:0] mix_c;
	logic [63:0] prod_c;

	// One byte per cycle: xor then multiply by the prime.
	// The prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1, so the product is a sum of shifts.
	assign byte_c = code[{idx_q[4:0], 3'b000} +: 8];
	assign mix_c  = h_q ^ {56'd0, byte_c};
	assign prod_c = (mix_c << 24) + (mix_c << 8) + (mix_c << 7) + (mix_c << 4)
	              + (mix_c << 1) + mix_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
			len_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				len_q  <= req.len;
			end else if (busy_q) begin
				if (idx_q == len_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			h_q <= HASH_OFFSET;
		end else if (busy_q && idx_q != len_q) begin
			h_q <= prod_c;
		end
	end

	assign hash     = h_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// File: hw/rtl/hashed_quote_cache_update.sv
// Quote cache update with a hashed, linearly probed instrument table.
// Input channel s_axis: one beat per market tick; tdata holds the four code
// words, bid, ask and tick time. Output channel m_axis: one beat per tick
// with status and slot in tuser and the echoed code and prices in tdata.
// After reset the block first runs a clearing pass over all 4096 slots,
// one slot per cycle, with s_axis_tready low; the table then starts empty.
// A tick passes through the byte-serial hash, one byte of its code at a
// time, then through each probed slot (memory read, then compare and write
// back); its result is valid right after the last check. An error tick
// skips hash and probe; its result is valid in the cycle after its beat.
// With the receiver ready, the next tick is taken once the result has been
// taken and the control has passed from its done state back to idle. One
// tick is in flight at a time; while m_axis_tready stalls, the finished
// result waits and no new tick is accepted until it has been taken.
module hashed_quote_cache_update import hqc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// code_word0..3, bid_price, ask_price, tick_time, 3 zero bits
	input  logic [447:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, slot_index
	output logic [14:0]  m_axis_tuser,
	// out_code_word0..3, out_bid, out_ask, mid_price, spread, quote_time, 5 zero bits
	output logic [575:0] m_axis_tdata
);

	localparam int REC_W = CODE_W + 1 + VAL_W;

	fsm_t state_q, state_d;

	logic [CODE_W-1:0] code_c, code_q;
	logic [5:0]        len_c;
	logic [VAL_W-1:0]  bid_q, ask_q, ts_q;
	logic [5:0]        len_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W:0]   probe_q;
	logic [SLOT_W-1:0] clr_q;
	status_t           res_status;
	logic              do_write;
	logic [SLOT_W-1:0] waddr;
	logic [REC_W-1:0]  wdata, rdata;
	logic [SLOT_W-1:0] raddr;
	hash_req_t         hreq;
	hash_sts_t         hsts;
	logic [63:0]       hash;
	logic              accept;
	logic              rec_used;
	logic [VAL_W-1:0]  rec_stamp;
	logic [CODE_W-1:0] rec_code;
	logic              bad_c;
	logic [VAL_W:0]    sum_c;
	logic [VAL_W-1:0]  spr_c;
	logic              finish;
	status_t           fin_status;
	logic              fin_write;
	logic              stale_c;

	// Canonical code: clear bytes after the first zero byte.
	always_comb begin
		logic seen;
		seen   = 1'b0;
		len_c  = 6'd32;
		code_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (!seen && s_axis_tdata[i*8 +: 8] == 8'd0) begin
				seen  = 1'b1;
				len_c = 6'(i);
			end
			if (!seen) begin
				code_c[i*8 +: 8] = s_axis_tdata[i*8 +: 8];
			end
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == FSM_IDLE) && !m_axis_tvalid;

	assign hreq.start = (state_q == FSM_HASH) && !hsts.busy && !hsts.done;
	assign hreq.len   = len_q;

	hqc_hash u_hash (
		.clk,
		.arst_n,
		.req  (hreq),
		.code (code_q),
		.sts  (hsts),
		.hash
	);

	// Slot record: code, used flag, stamp.
	assign {rec_code, rec_used, rec_stamp} = rdata;
	assign raddr = slot_q;

	hqc_ram #(.WIDTH(REC_W), .DEPTH(TABLE_SLOTS)) u_slots (
		.clk,
		.we    (do_write),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sum_c   = {1'b0, bid_q} + {1'b0, ask_q};
	assign spr_c   = ask_q - bid_q;
	assign stale_c = rec_stamp != '0 && ts_q < rec_stamp;
	assign bad_c   = 1'b0;

	// Decide the outcome of one probed slot.
	always_comb begin
		finish     = 1'b0;
		fin_status = ST_UPDATED;
		fin_write  = 1'b0;
		wdata      = {code_q, 1'b1, rec_stamp};
		if (!rec_used || rec_code == code_q) begin
			finish = 1'b1;
			if (!rec_used) begin
				wdata[VAL_W-1:0] = '0;
			end
			if (rec_used && stale_c) begin
				fin_status = ST_STALE;
				fin_write  = 1'b0;
			end else if (sum_c[VAL_W]) begin
				fin_status = ST_OVFL;
				fin_write  = !rec_used;
			end else begin
				fin_status = ST_UPDATED;
				fin_write  = 1'b1;
				wdata[VAL_W-1:0] = ts_q;
			end
		end else if (probe_q == PROBE_MAX - 1'b1) begin
			finish     = 1'b1;
			fin_status = ST_FULL;
		end
		if (bad_c) begin
			finish = 1'b0;
		end
		// The clearing pass writes empty records.
		if (state_q == FSM_CLEAR) begin
			wdata = '0;
		end
	end

	always_comb begin
		do_write = 1'b0;
		waddr    = slot_q;
		if (state_q == FSM_CLEAR) begin
			do_write = 1'b1;
			waddr    = clr_q;
		end else if (state_q == FSM_CHECK && finish) begin
			do_write = fin_write;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) state_d = FSM_IDLE;
			FSM_IDLE: begin
				if (accept) begin
					if (len_c == 6'd0 || len_c == 6'd32
					    || s_axis_tdata[256 +: VAL_W] == '0
					    || s_axis_tdata[319 +: VAL_W] == '0
					    || s_axis_tdata[382 +: VAL_W] == '0
					    || s_axis_tdata[256 +: VAL_W] > s_axis_tdata[319 +: VAL_W])
						state_d = FSM_DONE;
					else
						state_d = FSM_HASH;
				end
			end
			FSM_HASH:  if (hsts.done) state_d = FSM_READ;
			FSM_READ:  state_d = FSM_CHECK;
			FSM_CHECK: state_d = finish ? FSM_DONE : FSM_READ;
			FSM_DONE:  state_d = FSM_IDLE;
			default:   state_d = FSM_IDLE;
		endcase
	end

	// Status of the pending result.
	always_comb begin
		case (state_q)
			FSM_CHECK: res_status = fin_status;
			default: begin
				if (len_c == 6'd0) res_status = ST_EMPTY;
				else               res_status = ST_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_CLEAR;
			clr_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) clr_q <= clr_q + 1'b1;
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			if ((state_q == FSM_IDLE && accept && state_d == FSM_DONE)
			    || (state_q == FSM_CHECK && finish))
				m_axis_tvalid <= 1'b1;
		end
	end

	// Tick registers and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= code_c;
			len_q  <= len_c;
			bid_q  <= s_axis_tdata[256 +: VAL_W];
			ask_q  <= s_axis_tdata[319 +: VAL_W];
			ts_q   <= s_axis_tdata[382 +: VAL_W];
			probe_q <= '0;
			m_axis_tuser <= {12'd0, res_status};
			m_axis_tdata <= {320'd0, code_c};
		end
		if (hsts.done) begin
			slot_q <= hash[SLOT_W-1:0];
		end
		if (state_q == FSM_CHECK) begin
			if (finish) begin
				m_axis_tuser <= {(fin_status == ST_FULL) ? {SLOT_W{1'b0}} : slot_q,
				                 fin_status};
				if (fin_status == ST_UPDATED)
					m_axis_tdata <= {5'd0, ts_q, spr_c, bid_q + (spr_c >> 1), ask_q, bid_q,
					                 code_q};
				else
					m_axis_tdata <= {320'd0, code_q};
			end else begin
				slot_q  <= slot_q + 1'b1;
				probe_q <= probe_q + 1'b1;
			end
		end
	end

	// A result is only raised out of a probe check or an input error.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == FSM_CHECK || $past(state_q) == FSM_IDLE)
		else $error("result raised from wrong state");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> state_q == FSM_CLEAR || state_q == FSM_CHECK)
		else $error("slot write outside clear or check");

endmodule
